// ----- hdl/sm4_block_cipher_ecb_cbc_core_macros.svh -----
// Assertion macros for the SM4 ECB/CBC core.
// Used by the top level only; empty when SYNTH is defined.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_CORE_MACROS_SVH
`ifndef SYNTH
`define SM4_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("sm4 check failed");
`define SM4_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("sm4 never");
`else
`define SM4_ASSERT(lbl, clk, rst_n, prop)
`define SM4_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hdl/sm4_pkg.sv -----
// Shared types, constants and round functions for the SM4 core.
// No dependencies.
package sm4_pkg;

    localparam int unsigned NumRounds = 32;
    localparam int unsigned RndW      = $clog2(NumRounds);

    localparam logic [2:0] RegKeyHigh = 3'd0;
    localparam logic [2:0] RegKeyLow  = 3'd1;
    localparam logic [2:0] RegIvHigh  = 3'd2;
    localparam logic [2:0] RegIvLow   = 3'd3;
    localparam logic [2:0] RegDecrypt = 3'd4;
    localparam logic [2:0] RegChain   = 3'd5;

    localparam logic [31:0] Fk0 = 32'ha3b1bac6;
    localparam logic [31:0] Fk1 = 32'h56aa3350;
    localparam logic [31:0] Fk2 = 32'h677d9197;
    localparam logic [31:0] Fk3 = 32'hb27022dc;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic key_mode;     // 1: key schedule round, 0: data round
        logic load;         // load the four working words
        logic step;         // advance one round
    } round_ctrl_t;

    localparam logic [7:0] Sbox [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] x);
        tau = {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
    endfunction

    // CK byte j of round i is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [RndW-1:0] i);
        logic [7:0] base;
        // base = 28*i mod 256 = 32i - 4i
        base = {i[2:0], 5'b00000} - {1'b0, i[4:0], 2'b00};
        ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
    endfunction

endpackage

// ----- hdl/sm4_block_cipher_ecb_cbc_core.sv -----
// SM4 ECB/CBC engine. An input request is taken only when idle; it runs
// 32 rounds on one shared round unit (one round per cycle), the result is
// then held until taken, and no new block is taken before the previous result
// has been taken. A key write re-expands the 32 round keys on the same unit
// (one load, then 32 rounds), also after reset,
// during which no input request is taken. Configuration requests are taken
// only when idle.
// Depends on sm4_pkg, sm4_ctrl, sm4_round and the assertion macro header.
`include "sm4_block_cipher_ecb_cbc_core_macros.svh"
module sm4_block_cipher_ecb_cbc_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_low, block_high
    input  logic         s_axis_tuser,   // message_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // result_low, result_high
);

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        decrypt_reg, chain_reg;
    logic [127:0] chain_value_reg;
    logic [127:0] blk_in_reg;
    logic [31:0] rk_mem [sm4_pkg::NumRounds];
    logic        key_pending_reg;

    sm4_pkg::state_t            state;
    logic [sm4_pkg::RndW-1:0]   rnd;
    sm4_pkg::round_ctrl_t       ctrl;
    logic [127:0] words;
    logic [31:0]  new_word;
    logic [127:0] load_words;
    logic [31:0]  round_key;
    logic         cfg_fire, in_fire, out_fire, key_start;
    logic [127:0] blk_in, chain_now, enc_out, result;
    logic [63:0]  blk_high, blk_low;

    assign cfg_ready = (state == sm4_pkg::ST_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign blk_high  = s_axis_tdata[63:0];
    assign blk_low   = s_axis_tdata[127:64];
    assign blk_in    = {blk_high, blk_low};
    assign key_start = key_pending_reg && !cfg_fire && (state == sm4_pkg::ST_IDLE);
    assign s_axis_tready = (state == sm4_pkg::ST_IDLE) && !key_pending_reg;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state == sm4_pkg::ST_DONE);
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    assign chain_now = s_axis_tuser ? {iv_high_reg, iv_low_reg} : chain_value_reg;

    always_comb
    begin
        if (ctrl.key_mode)
            load_words = {key_high_reg, key_low_reg} ^ {sm4_pkg::Fk0, sm4_pkg::Fk1,
                                                      sm4_pkg::Fk2, sm4_pkg::Fk3};
        else if (chain_reg && !decrypt_reg)
            load_words = blk_in ^ chain_now;
        else
            load_words = blk_in;
    end

    assign round_key = (state == sm4_pkg::ST_KEY) ? sm4_pkg::ck_word(rnd)
                     : rk_mem[decrypt_reg ? ~rnd : rnd];

    sm4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_start (key_start),
        .blk_start (in_fire),
        .out_taken (out_fire),
        .state     (state),
        .rnd       (rnd),
        .ctrl      (ctrl)
    );

    sm4_round u_round (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_words (load_words),
        .round_key  (round_key),
        .words      (words),
        .new_word   (new_word)
    );

    assign enc_out = {words[31:0], words[63:32], words[95:64], words[127:96]};
    assign result  = (chain_reg && decrypt_reg) ? enc_out ^ chain_value_reg : enc_out;
    // result_high in the low half
    assign m_axis_tdata = {result[63:0], result[127:64]};

    always_ff @(posedge clk)
    begin
        if (state == sm4_pkg::ST_KEY)
            rk_mem[rnd] <= new_word;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            blk_in_reg <= blk_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            iv_high_reg     <= '0;
            iv_low_reg      <= '0;
            decrypt_reg     <= 1'b0;
            chain_reg       <= 1'b0;
            chain_value_reg <= '0;
            key_pending_reg <= 1'b1;   // expand the all-zero key after reset
        end
        else
        begin
            if (key_start)
                key_pending_reg <= 1'b0;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    sm4_pkg::RegKeyHigh:
                    begin
                        key_high_reg    <= cfg_data;
                        key_pending_reg <= 1'b1;
                    end
                    sm4_pkg::RegKeyLow:
                    begin
                        key_low_reg     <= cfg_data;
                        key_pending_reg <= 1'b1;
                    end
                    sm4_pkg::RegIvHigh:  iv_high_reg <= cfg_data;
                    sm4_pkg::RegIvLow:   iv_low_reg  <= cfg_data;
                    sm4_pkg::RegDecrypt: decrypt_reg <= cfg_data[0];
                    sm4_pkg::RegChain:   chain_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_fire)
                chain_value_reg <= chain_now;
            if (out_fire && chain_reg)
                chain_value_reg <= decrypt_reg ? blk_in_reg : enc_out;
        end
    end

    `SM4_ASSERT(a_out_only_done, clk, rst_n, m_axis_tvalid |-> state == sm4_pkg::ST_DONE)
    `SM4_ASSERT(a_run_to_done, clk, rst_n,
        (state == sm4_pkg::ST_RUN && rnd == sm4_pkg::RndW'(sm4_pkg::NumRounds - 1)) |=> m_axis_tvalid)
    `SM4_ASSERT_NEVER(a_no_take_busy, clk, rst_n, in_fire && state != sm4_pkg::ST_IDLE)

endmodule

// ----- hdl/sm4_round.sv -----
// One shared SM4 round unit: S-box layer plus the linear transform of
// either the key schedule or the data path. Uses sm4_pkg.
module sm4_round (
    input  logic                   clk,
    input  sm4_pkg::round_ctrl_t   ctrl,
    input  logic [127:0]           load_words,
    input  logic [31:0]            round_key,
    output logic [127:0]           words,
    output logic [31:0]            new_word
);

    logic [127:0] words_reg;
    logic [127:0] words_next;
    logic [31:0]  t_in;
    logic [31:0]  t_s;

    assign t_in = words_reg[95:64] ^ words_reg[63:32] ^ words_reg[31:0] ^ round_key;
    assign t_s  = sm4_pkg::tau(t_in);

    always_comb
    begin
        if (ctrl.key_mode)
        begin
            new_word = words_reg[127:96] ^ t_s ^ {t_s[18:0], t_s[31:19]}
                     ^ {t_s[8:0], t_s[31:9]};
        end
        else
        begin
            new_word = words_reg[127:96] ^ t_s ^ {t_s[29:0], t_s[31:30]}
                     ^ {t_s[21:0], t_s[31:22]} ^ {t_s[13:0], t_s[31:14]}
                     ^ {t_s[7:0], t_s[31:8]};
        end
    end

    always_comb
    begin
        words_next = words_reg;
        if (ctrl.load)
        begin
            words_next = load_words;
        end
        else if (ctrl.step)
        begin
            // window slides: oldest word drops out, new word enters last
            words_next = {words_reg[95:0], new_word};
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    assign words = words_reg;

endmodule

// ----- hdl/sm4_ctrl.sv -----
// Sequencer for key expansion and the 32 data rounds.
// Uses sm4_pkg.
module sm4_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_start,
    input  logic                          blk_start,
    input  logic                          out_taken,
    output sm4_pkg::state_t               state,
    output logic [sm4_pkg::RndW-1:0]      rnd,
    output sm4_pkg::round_ctrl_t          ctrl
);

    sm4_pkg::state_t            state_reg, state_next;
    logic [sm4_pkg::RndW-1:0]   rnd_reg, rnd_next;
    logic                       last_rnd;

    assign last_rnd = (rnd_reg == sm4_pkg::RndW'(sm4_pkg::NumRounds - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sm4_pkg::ST_IDLE:
            begin
                if (key_start)
                    state_next = sm4_pkg::ST_KEY;
                else if (blk_start)
                    state_next = sm4_pkg::ST_RUN;
            end
            sm4_pkg::ST_KEY:
            begin
                if (last_rnd)
                    state_next = sm4_pkg::ST_IDLE;
            end
            sm4_pkg::ST_RUN:
            begin
                if (last_rnd)
                    state_next = sm4_pkg::ST_DONE;
            end
            sm4_pkg::ST_DONE:
            begin
                if (out_taken)
                    state_next = sm4_pkg::ST_IDLE;
            end
            default: state_next = sm4_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        rnd_next = rnd_reg;
        unique case (state_reg)
            sm4_pkg::ST_IDLE:
            begin
                ctrl.load     = key_start || blk_start;
                ctrl.key_mode = key_start;
                rnd_next      = '0;
            end
            sm4_pkg::ST_KEY:
            begin
                ctrl.key_mode = 1'b1;
                ctrl.step     = 1'b1;
                rnd_next      = rnd_reg + 1'b1;
            end
            sm4_pkg::ST_RUN:
            begin
                ctrl.step = 1'b1;
                rnd_next  = rnd_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm4_pkg::ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    assign state = state_reg;
    assign rnd   = rnd_reg;

endmodule
